@@ rtl/rmir_pkg.sv @@
// ----------------------------------------------------------------------------
// rmir_pkg
// Shared types and constants for the running median block: request modes,
// error codes, cell operations and the control word sent to each cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package rmir_pkg;

    localparam int CAPACITY_DEF   = 256;
    localparam int VALUE_BITS_DEF = 31;

    localparam int MODE_W  = 2;
    localparam int VALUE_W = 31;
    localparam int COUNT_W = 9;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_PUSH,
        OP_POP,
        OP_REPLACE_FRONT,
        OP_REPLACE_EXTREME
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     desc;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/rmir_cell.sv @@
// ----------------------------------------------------------------------------
// rmir_cell
// One storage cell of a sorted chain. It compares its value with the request
// key and takes its own, its neighbor's, the key or the head value.
// ----------------------------------------------------------------------------
`default_nettype none

module rmir_cell #(
    parameter int VALUE_BITS = rmir_pkg::VALUE_BITS_DEF
) (
    input  wire                        clk,
    input  rmir_pkg::cell_ctrl_t       ctrl,
    input  wire                        is_first,
    input  wire                        valid,
    input  wire  [VALUE_BITS-1:0]      key,
    input  wire  [VALUE_BITS-1:0]      head,
    input  wire  [VALUE_BITS-1:0]      prev_val,
    input  wire                        prev_before,
    input  wire  [VALUE_BITS-1:0]      next_val,
    input  wire                        next_before,
    output logic [VALUE_BITS-1:0]      val,
    output logic                       ahead
);

    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] val_next;

    assign val   = val_reg;
    assign ahead = valid && (ctrl.desc ? (val_reg >= key) : (val_reg <= key));

    always_comb
    begin
        unique case (ctrl.op)
            rmir_pkg::OP_HOLD:
            begin
                val_next = val_reg;
            end
            rmir_pkg::OP_INSERT:
            begin
                if (ahead)
                begin
                    val_next = val_reg;
                end
                else if (is_first || prev_before)
                begin
                    val_next = key;
                end
                else
                begin
                    val_next = prev_val;
                end
            end
            rmir_pkg::OP_PUSH:
            begin
                val_next = is_first ? head : prev_val;
            end
            rmir_pkg::OP_POP:
            begin
                val_next = next_val;
            end
            rmir_pkg::OP_REPLACE_FRONT:
            begin
                val_next = is_first ? head : val_reg;
            end
            rmir_pkg::OP_REPLACE_EXTREME:
            begin
                if (next_before)
                begin
                    val_next = next_val;
                end
                else if (ahead)
                begin
                    val_next = key;
                end
                else
                begin
                    val_next = val_reg;
                end
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

`default_nettype wire

@@ rtl/rmir_chain.sv @@
// ----------------------------------------------------------------------------
// rmir_chain
// A row of cells holding one half of the sorted store, extreme value first.
// Cells below the fill size are valid; the rest hold don't-care data.
// ----------------------------------------------------------------------------
`default_nettype none

module rmir_chain #(
    parameter int DEPTH      = rmir_pkg::CAPACITY_DEF / 2,
    parameter int VALUE_BITS = rmir_pkg::VALUE_BITS_DEF,
    parameter int SIZE_W     = $clog2(DEPTH + 1)
) (
    input  wire                        clk,
    input  rmir_pkg::cell_ctrl_t       ctrl,
    input  wire  [SIZE_W-1:0]          size,
    input  wire  [VALUE_BITS-1:0]      key,
    input  wire  [VALUE_BITS-1:0]      head,
    output logic [VALUE_BITS-1:0]      front
);

    logic [VALUE_BITS-1:0] vals   [DEPTH];
    logic                  befores[DEPTH];
    logic [VALUE_BITS-1:0] prev_v [DEPTH];
    logic                  prev_b [DEPTH];
    logic [VALUE_BITS-1:0] next_v [DEPTH];
    logic                  next_b [DEPTH];
    logic                  valid  [DEPTH];

    assign front = vals[0];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign valid[i] = (SIZE_W'(i) < size);

        if (i == 0)
        begin : g_first
            assign prev_v[i] = '0;
            assign prev_b[i] = 1'b0;
        end
        else
        begin : g_mid
            assign prev_v[i] = vals[i-1];
            assign prev_b[i] = befores[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_v[i] = '0;
            assign next_b[i] = 1'b0;
        end
        else
        begin : g_inner
            assign next_v[i] = vals[i+1];
            assign next_b[i] = befores[i+1];
        end

        rmir_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .is_first    (i == 0),
            .valid       (valid[i]),
            .key         (key),
            .head        (head),
            .prev_val    (prev_v[i]),
            .prev_before (prev_b[i]),
            .next_val    (next_v[i]),
            .next_before (next_b[i]),
            .val         (vals[i]),
            .ahead       (befores[i])
        );
    end

endmodule

`default_nettype wire

@@ rtl/running_median_insert_remove.sv @@
// ----------------------------------------------------------------------------
// running_median_insert_remove
// Running lower median over a bounded multiset held in two sorted cell chains.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low;
// busy stays low, so a new request may be issued in every cycle. Modes are
// insert value, remove the current median, and clear.
// The result appears in the cycle after the request, on median_value,
// removed_value, element_count and op_error, marked by done for exactly one
// cycle. The receiver cannot stall, and none is needed: one request per cycle
// in, one result per cycle out.
// The store is split into a lower chain, largest value first, and an upper
// chain, smallest value first; the lower chain holds the extra element for an
// odd count, so the median always sits in the first lower cell. Every request
// completes at the clock edge at which the compare-and-shift cells of both
// chains update together.
// Reset empties the set and clears done; the cell contents are not cleared,
// since only cells below the fill size are ever used. Insert while full and
// remove while empty report an error and change nothing.
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_insert_remove #(
    parameter int CAPACITY   = rmir_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = rmir_pkg::VALUE_BITS_DEF
) (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              start,
    output logic                             busy,
    input  wire  [rmir_pkg::MODE_W-1:0]      mode,
    input  wire  [rmir_pkg::VALUE_W-1:0]     value,
    output logic                             done,
    output logic [rmir_pkg::VALUE_W-1:0]     median_value,
    output logic [rmir_pkg::VALUE_W-1:0]     removed_value,
    output logic [rmir_pkg::COUNT_W-1:0]     element_count,
    output logic [1:0]                       op_error
);

    localparam int LCAP = (CAPACITY + 1) / 2;
    localparam int UCAP = CAPACITY / 2;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int LSW  = $clog2(LCAP + 1);
    localparam int USW  = $clog2(UCAP + 1);

    logic                    done_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           count_next;
    logic [VALUE_BITS-1:0]   removed_reg;
    logic [VALUE_BITS-1:0]   removed_next;
    rmir_pkg::err_t          err_reg;
    rmir_pkg::err_t          err_next;

    rmir_pkg::cell_ctrl_t    lctrl;
    rmir_pkg::cell_ctrl_t    uctrl;
    logic [VALUE_BITS-1:0]   v;
    logic [VALUE_BITS-1:0]   l0;
    logic [VALUE_BITS-1:0]   u0;
    logic [LSW-1:0]          lsize;
    logic [USW-1:0]          usize;
    logic [CW:0]             count_inc;
    logic                    odd;

    assign v         = VALUE_BITS'(value);
    assign count_inc = {1'b0, count_reg} + (CW+1)'(1);
    assign lsize     = LSW'(count_inc >> 1);
    assign usize     = USW'(count_reg >> 1);
    assign odd       = count_reg[0];

    always_comb
    begin
        lctrl.op     = rmir_pkg::OP_HOLD;
        lctrl.desc   = 1'b1;
        uctrl.op     = rmir_pkg::OP_HOLD;
        uctrl.desc   = 1'b0;
        count_next   = count_reg;
        removed_next = '0;
        err_next     = rmir_pkg::ERR_NONE;
        if (start && !busy)
        begin
            unique case (mode)
                rmir_pkg::MODE_INSERT:
                begin
                    if (count_reg == CW'(CAPACITY))
                    begin
                        err_next = rmir_pkg::ERR_FULL;
                    end
                    else
                    begin
                        count_next = count_inc[CW-1:0];
                        if (odd)
                        begin
                            if (v >= l0)
                            begin
                                uctrl.op = rmir_pkg::OP_INSERT;
                            end
                            else
                            begin
                                lctrl.op = rmir_pkg::OP_REPLACE_EXTREME;
                                uctrl.op = rmir_pkg::OP_PUSH;
                            end
                        end
                        else if ((usize != '0) && (v > u0))
                        begin
                            lctrl.op = rmir_pkg::OP_PUSH;
                            uctrl.op = rmir_pkg::OP_REPLACE_EXTREME;
                        end
                        else
                        begin
                            lctrl.op = rmir_pkg::OP_INSERT;
                        end
                    end
                end
                rmir_pkg::MODE_REMOVE:
                begin
                    if (count_reg == '0)
                    begin
                        err_next = rmir_pkg::ERR_EMPTY;
                    end
                    else
                    begin
                        count_next   = count_reg - CW'(1);
                        removed_next = l0;
                        if (odd)
                        begin
                            lctrl.op = rmir_pkg::OP_POP;
                        end
                        else
                        begin
                            lctrl.op = rmir_pkg::OP_REPLACE_FRONT;
                            uctrl.op = rmir_pkg::OP_POP;
                        end
                    end
                end
                rmir_pkg::MODE_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    rmir_chain #(
        .DEPTH      (LCAP),
        .VALUE_BITS (VALUE_BITS),
        .SIZE_W     (LSW)
    ) u_lower (
        .clk   (clk),
        .ctrl  (lctrl),
        .size  (lsize),
        .key   (v),
        .head  (u0),
        .front (l0)
    );

    rmir_chain #(
        .DEPTH      (UCAP),
        .VALUE_BITS (VALUE_BITS),
        .SIZE_W     (USW)
    ) u_upper (
        .clk   (clk),
        .ctrl  (uctrl),
        .size  (usize),
        .key   (v),
        .head  (l0),
        .front (u0)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            count_reg <= '0;
            err_reg   <= rmir_pkg::ERR_NONE;
        end
        else
        begin
            done_reg <= start && !busy;
            if (start && !busy)
            begin
                count_reg <= count_next;
                err_reg   <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            removed_reg <= removed_next;
        end
    end

    assign busy          = 1'b0;
    assign done          = done_reg;
    assign median_value  = (count_reg == '0) ? '0 : rmir_pkg::VALUE_W'(l0);
    assign removed_value = rmir_pkg::VALUE_W'(removed_reg);
    assign element_count = rmir_pkg::COUNT_W'(count_reg);
    assign op_error      = err_reg;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done)
        else $error("result strobe missing after a request");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |=> !done)
        else $error("result strobe without a request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count beyond capacity");

    a_full_error: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (err_reg == rmir_pkg::ERR_FULL)) |-> (count_reg == CW'(CAPACITY)))
        else $error("full error reported while not full");

    a_empty_error: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (err_reg == rmir_pkg::ERR_EMPTY)) |->
            ((count_reg == '0) && (removed_reg == '0)))
        else $error("empty error reported with values held");

endmodule

`default_nettype wire

@@ sim/tb_running_median_insert_remove.sv @@
// ----------------------------------------------------------------------------
// tb_running_median_insert_remove
// Self-checking testbench for the running lower median block. A driver feeds
// requests from a queue with random gaps, and a monitor predicts each result
// from its own sorted copy of the multiset and compares every field.
// ----------------------------------------------------------------------------
module tb_running_median_insert_remove;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD   = 10;
    localparam int STORE_DEPTH   = rmir_pkg::CAPACITY_DEF;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_BLOCKS = 20;
    localparam int BLOCK_ITEMS   = 40;

    localparam int MODE_W  = rmir_pkg::MODE_W;
    localparam int VALUE_W = rmir_pkg::VALUE_W;
    localparam int COUNT_W = rmir_pkg::COUNT_W;

    localparam logic [MODE_W-1:0]  MODE_INSERT = rmir_pkg::MODE_INSERT;
    localparam logic [MODE_W-1:0]  MODE_REMOVE = rmir_pkg::MODE_REMOVE;
    localparam logic [MODE_W-1:0]  MODE_CLEAR  = rmir_pkg::MODE_CLEAR;
    localparam logic [MODE_W-1:0]  MODE_NOP    = 2'd3;
    localparam logic [VALUE_W-1:0] VALUE_MAX   = {VALUE_W{1'b1}};

    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [VALUE_W-1:0] value;
        int unsigned        gap;
        bit                 pause;
    } request_t;

    typedef struct {
        logic [VALUE_W-1:0] median;
        logic [VALUE_W-1:0] removed;
        logic [COUNT_W-1:0] count;
        rmir_pkg::err_t     err;
    } median_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic [MODE_W-1:0]  mode = '0;
    logic [VALUE_W-1:0] value = '0;
    logic               busy;
    logic               done;
    logic [VALUE_W-1:0] median_value;
    logic [VALUE_W-1:0] removed_value;
    logic [COUNT_W-1:0] element_count;
    logic [1:0]         op_error;

    request_t           pending_requests[$];
    median_result_t     expected_results[$];
    logic [VALUE_W-1:0] held_values[$];

    bit                 request_taken = 1'b0;
    bit                 item_loaded = 1'b0;
    request_t           current_item;
    int unsigned        gap_left = 0;
    int unsigned        fail_count = 0;
    int unsigned        cycle_count = 0;

    running_median_insert_remove uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .value         (value),
        .done          (done),
        .median_value  (median_value),
        .removed_value (removed_value),
        .element_count (element_count),
        .op_error      (op_error)
    );

    always #HALF_PERIOD clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_running_median_insert_remove NOT OK");
            $finish;
        end
    end

    task automatic apply_request(input logic [MODE_W-1:0] req_mode,
                                 input logic [VALUE_W-1:0] req_value,
                                 output median_result_t res);
        int pos;
        res.removed = '0;
        res.err = rmir_pkg::ERR_NONE;
        if (req_mode == MODE_INSERT)
        begin
            if (held_values.size() >= STORE_DEPTH)
                res.err = rmir_pkg::ERR_FULL;
            else
            begin
                pos = 0;
                while (pos < held_values.size() && held_values[pos] <= req_value)
                    pos++;
                held_values.insert(pos, req_value);
            end
        end
        else if (req_mode == MODE_REMOVE)
        begin
            if (held_values.size() == 0)
                res.err = rmir_pkg::ERR_EMPTY;
            else
            begin
                pos = (held_values.size() - 1) / 2;
                res.removed = held_values[pos];
                held_values.delete(pos);
            end
        end
        else if (req_mode == MODE_CLEAR)
            held_values.delete();
        if (held_values.size() == 0)
            res.median = '0;
        else
            res.median = held_values[(held_values.size() - 1) / 2];
        res.count = COUNT_W'(held_values.size());
    endtask

    task automatic report_mismatch(input string field, input longint unsigned want,
                                   input longint unsigned got);
        if (fail_count < MAX_REPORTS)
            $display("mismatch on %s: expected %0d, got %0d", field, want, got);
        fail_count++;
    endtask

    // Driver: requests change on the falling edge, one assignment per signal.
    always @(negedge clk)
    begin
        bit drive;
        drive = 1'b0;
        if (rst_n && !(start && !request_taken))
        begin
            request_taken = 1'b0;
            if (!item_loaded && pending_requests.size() > 0)
            begin
                if (pending_requests[0].pause)
                begin
                    if (expected_results.size() == 0)
                        void'(pending_requests.pop_front());
                end
                else
                begin
                    current_item = pending_requests.pop_front();
                    item_loaded = 1'b1;
                    gap_left = current_item.gap;
                end
            end
            if (item_loaded)
            begin
                if (gap_left == 0)
                begin
                    drive = 1'b1;
                    item_loaded = 1'b0;
                end
                else
                    gap_left--;
            end
            start <= drive;
            if (drive)
            begin
                mode <= current_item.mode;
                value <= current_item.value;
            end
            else
            begin
                mode <= MODE_W'($urandom);
                value <= VALUE_W'($urandom);
            end
        end
    end

    // Monitor: results are checked before the request of the same edge is taken.
    always @(posedge clk)
    begin
        median_result_t want;
        median_result_t next;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected result, element_count", 0, element_count);
                else
                begin
                    want = expected_results.pop_front();
                    if (median_value !== want.median)
                        report_mismatch("median_value", want.median, median_value);
                    if (removed_value !== want.removed)
                        report_mismatch("removed_value", want.removed, removed_value);
                    if (element_count !== want.count)
                        report_mismatch("element_count", want.count, element_count);
                    if (op_error !== 2'(want.err))
                        report_mismatch("op_error", want.err, op_error);
                end
            end
            if (start && !busy)
            begin
                request_taken = 1'b1;
                apply_request(mode, value, next);
                expected_results.insert(expected_results.size(), next);
            end
        end
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return VALUE_W'($urandom_range(0, 15));
        else if (sel == 4)
            return ($urandom_range(0, 1) == 0) ? '0 : VALUE_MAX;
        else if (sel == 5)
            return VALUE_MAX - VALUE_W'($urandom_range(0, 3));
        else
            return VALUE_W'($urandom);
    endfunction

    task automatic queue_request(input logic [MODE_W-1:0] req_mode,
                                 input logic [VALUE_W-1:0] req_value,
                                 input int unsigned gap);
        request_t item;
        item.mode = req_mode;
        item.value = req_value;
        item.gap = gap;
        item.pause = 1'b0;
        pending_requests.insert(pending_requests.size(), item);
    endtask

    task automatic queue_pause();
        request_t item;
        item.mode = MODE_NOP;
        item.value = '0;
        item.gap = 0;
        item.pause = 1'b1;
        pending_requests.insert(pending_requests.size(), item);
    endtask

    function automatic int unsigned pick_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 7);
    endfunction

    initial
    begin
        int unsigned insert_pct;
        int unsigned remove_pct;
        int unsigned roll;
        bit burst;
        logic [MODE_W-1:0] next_mode;

        // Short directed sequence covering the empty, duplicate and extreme cases.
        queue_request(MODE_REMOVE, VALUE_MAX, pick_gap(1'b0));
        queue_request(MODE_NOP, VALUE_MAX, pick_gap(1'b0));
        queue_request(MODE_CLEAR, VALUE_MAX, pick_gap(1'b0));
        queue_request(MODE_INSERT, 31'd100, pick_gap(1'b0));
        queue_request(MODE_INSERT, '0, pick_gap(1'b0));
        queue_request(MODE_INSERT, VALUE_MAX, pick_gap(1'b0));
        queue_request(MODE_INSERT, 31'd100, pick_gap(1'b0));
        queue_request(MODE_INSERT, 31'd100, pick_gap(1'b0));
        queue_request(MODE_NOP, 31'h2AAAAAAA, pick_gap(1'b0));
        queue_request(MODE_REMOVE, VALUE_MAX, pick_gap(1'b0));
        queue_request(MODE_REMOVE, 31'h55555555, pick_gap(1'b0));
        queue_request(MODE_INSERT, 31'd5, pick_gap(1'b0));
        repeat (5) queue_request(MODE_REMOVE, pick_value(), pick_gap(1'b0));
        queue_request(MODE_INSERT, VALUE_MAX, 0);
        queue_request(MODE_INSERT, VALUE_MAX, 0);
        queue_request(MODE_REMOVE, '0, 0);
        queue_request(MODE_CLEAR, '0, 0);
        queue_request(MODE_REMOVE, '0, 0);
        queue_request(MODE_NOP, '0, 0);
        queue_pause();

        // Fill the store completely, then push against the full limit.
        for (int i = 0; i < STORE_DEPTH; i++)
            queue_request(MODE_INSERT, pick_value(), pick_gap(i % 64 < 16));
        queue_request(MODE_INSERT, VALUE_MAX, pick_gap(1'b0));
        queue_request(MODE_INSERT, '0, 0);
        queue_request(MODE_INSERT, pick_value(), pick_gap(1'b0));
        queue_request(MODE_NOP, pick_value(), pick_gap(1'b0));
        queue_request(MODE_REMOVE, pick_value(), pick_gap(1'b0));
        queue_request(MODE_INSERT, pick_value(), pick_gap(1'b0));
        queue_request(MODE_INSERT, pick_value(), pick_gap(1'b0));
        queue_pause();
        queue_request(MODE_CLEAR, pick_value(), pick_gap(1'b0));

        // Random blocks with varying insert and remove bias.
        for (int b = 0; b < RANDOM_BLOCKS; b++)
        begin
            burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0:       begin insert_pct = 75; remove_pct = 20; end
                1:       begin insert_pct = 30; remove_pct = 65; end
                default: begin insert_pct = 50; remove_pct = 45; end
            endcase
            for (int i = 0; i < BLOCK_ITEMS; i++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < insert_pct)
                    next_mode = MODE_INSERT;
                else if (roll < insert_pct + remove_pct)
                    next_mode = MODE_REMOVE;
                else if (roll < insert_pct + remove_pct + 2)
                    next_mode = MODE_CLEAR;
                else
                    next_mode = MODE_NOP;
                queue_request(next_mode, pick_value(), pick_gap(burst));
            end
            if (b % 5 == 4)
                queue_pause();
        end

        wait (rst_n);
        while (pending_requests.size() != 0 || item_loaded || start
               || expected_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb_running_median_insert_remove OK");
        else
            $display("tb_running_median_insert_remove NOT OK");
        $finish;
    end

endmodule

@@ running_median_insert_remove.f @@
rtl/rmir_pkg.sv
rtl/rmir_cell.sv
rtl/rmir_chain.sv
rtl/running_median_insert_remove.sv
sim/tb_running_median_insert_remove.sv
